### design/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
package sem_pkg;

    // Pixel, row counter and configuration field widths
    localparam int PixW = 8;
    localparam int RowW = 12;
    localparam int CfgIdxW = 8;
    localparam int CfgDataW = 12;
    localparam int WidthFieldW = 11;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgIdxWidth = 8'd0;
    localparam logic [CfgIdxW-1:0] CfgIdxHeight = 8'd1;

    // Output queue
    localparam int FifoDepth = 4;
    localparam int FifoPtrW = 2;
    localparam int FifoCntW = 3;

    // Row and frame marks that ride along with a pixel
    typedef struct packed {
        logic row_end;
        logic frame_end;
    } t_tag;

    // One result item
    typedef struct packed {
        logic [PixW-1:0] edge_res;
        t_tag            tag;
    } t_res;

endpackage

### design/sobel_edge_magnitude_3x3.sv
// Sobel 3x3 edge magnitude over a raster 8-bit grayscale stream. Takes one pixel
// per clock while tready is high on the slave stream and returns min(|Gx|+|Gy|,
// 255) for interior pixels only, so a W x H frame yields (W-2) x (H-2) results;
// tlast marks the last result of each output row, tuser[0] the last result of
// the frame. Border pixels are consumed without a result. The two previous rows
// live in one MAX_WIDTH x 16 RAM (one read and one write port) that is read when
// a pixel is taken and written back the next cycle; a column is revisited only
// after at least three transfers, so no forwarding is needed. A result passes
// the stage 1 registers and the registered gradient stage before it is written
// into the output queue, from which it can leave once stored. tready stays high
// at one pixel per clock and drops only when the 4-entry output queue plus the
// results in flight would exceed its room under output backpressure.
// frame_width (index 0) is clamped to 3..MAX_WIDTH and frame_height (index 1)
// raised to at least 3; a write to either of them restarts the frame counters.
// Write registers only while no results are outstanding. Line-store contents
// are not cleared after reset: unwritten entries never reach a result.
module sobel_edge_magnitude_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream, tdata: [7:0] pixel
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [sem_pkg::PixW-1:0]           i_s_axis_tdata,
    // master stream, tdata: [7:0] edge_res
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [sem_pkg::PixW-1:0]           o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    // tuser: [0] frame_end
    output logic [0:0]                         o_m_axis_tuser,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sem_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [sem_pkg::CfgDataW-1:0]       i_cfg_data
);
    import sem_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int ResetWidth = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam logic [CW-1:0] ResetLastCol = CW'(ResetWidth - 1);
    localparam logic [RowW-1:0] ResetLastRow = RowW'(479);

    // frame geometry, held as last column / last row indexes
    logic [CW-1:0]   r_last_col, n_last_col;
    logic [RowW-1:0] r_last_row, n_last_row;
    logic [CW-1:0]   r_col, n_col;
    logic [RowW-1:0] r_row, n_row;

    // stage 1: line store read data is valid here
    logic            r_act1;
    logic            r_prod1;
    t_tag            r_tag1;
    logic [PixW-1:0] r_pix1;
    logic [CW-1:0]   r_addr1;

    logic              s_xfer;
    logic              cfg_xfer;
    logic              cfg_hit;
    logic              at_last_col, at_last_row;
    logic              prod0;
    t_tag              tag0;
    logic [2*PixW-1:0] ls_rd_data;
    logic              g_valid;
    t_res              g_res;
    t_res              q_res;
    logic [FifoCntW-1:0] q_count;
    logic [FifoCntW-1:0] in_use;
    int                w_int, h_int;

    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = cfg_xfer && ((i_cfg_index == CfgIdxWidth) ||
                                      (i_cfg_index == CfgIdxHeight));

    // results in flight plus queued must leave room for one more
    assign in_use = FifoCntW'(r_prod1) + FifoCntW'(g_valid) + q_count;
    assign o_s_axis_tready = i_rst_n && (in_use < FifoCntW'(FifoDepth));
    assign s_xfer = i_s_axis_tvalid && o_s_axis_tready;

    assign at_last_col   = (r_col == r_last_col);
    assign at_last_row   = (r_row == r_last_row);
    assign prod0         = (r_row >= RowW'(2)) && (r_col >= CW'(2));
    assign tag0.row_end   = at_last_col;
    assign tag0.frame_end = at_last_col && at_last_row;

    // clamp written geometry
    always_comb begin
        w_int = int'(i_cfg_data[WidthFieldW-1:0]);
        h_int = int'(i_cfg_data);
        if (w_int < 3) begin
            w_int = 3;
        end
        if (w_int > MAX_WIDTH) begin
            w_int = MAX_WIDTH;
        end
        if (h_int < 3) begin
            h_int = 3;
        end
        n_last_col = r_last_col;
        n_last_row = r_last_row;
        if (cfg_xfer && (i_cfg_index == CfgIdxWidth)) begin
            n_last_col = CW'(w_int - 1);
        end
        if (cfg_xfer && (i_cfg_index == CfgIdxHeight)) begin
            n_last_row = RowW'(h_int - 1);
        end
    end

    // raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (s_xfer) begin
            if (at_last_col) begin
                n_col = '0;
                n_row = at_last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= ResetLastCol;
            r_last_row <= ResetLastRow;
            r_col      <= '0;
            r_row      <= '0;
            r_act1     <= 1'b0;
            r_prod1    <= 1'b0;
        end else begin
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
            r_col      <= n_col;
            r_row      <= n_row;
            r_act1     <= s_xfer;
            r_prod1    <= s_xfer && prod0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_tag1  <= tag0;
            r_pix1  <= i_s_axis_tdata;
            r_addr1 <= r_col;
        end
    end

    // read on transfer, write back {row one back, new pixel} in the following cycle
    sem_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (s_xfer),
        .i_rd_addr (r_col),
        .o_rd_data (ls_rd_data),
        .i_wr_en   (r_act1),
        .i_wr_addr (r_addr1),
        .i_wr_data ({ls_rd_data[PixW-1:0], r_pix1})
    );

    sem_grad u_grad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_act   (r_act1),
        .i_prod  (r_prod1),
        .i_tag   (r_tag1),
        .i_top   (ls_rd_data[2*PixW-1:PixW]),
        .i_mid   (ls_rd_data[PixW-1:0]),
        .i_bot   (r_pix1),
        .o_valid (g_valid),
        .o_res   (g_res)
    );

    sem_out_fifo u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (g_valid),
        .i_wr_data (g_res),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_rd_data (q_res),
        .o_count   (q_count)
    );

    assign o_m_axis_tdata    = q_res.edge_res;
    assign o_m_axis_tlast    = q_res.tag.row_end;
    assign o_m_axis_tuser[0] = q_res.tag.frame_end;

endmodule

### design/sem_line_store.sv
// Line store: one synchronous RAM, each entry holds {row two back, row one back}.
module sem_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    output logic [2*sem_pkg::PixW-1:0]    o_rd_data,
    input  logic                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [2*sem_pkg::PixW-1:0]    i_wr_data
);
    import sem_pkg::*;

    logic [2*PixW-1:0] r_mem [DEPTH];
    logic [2*PixW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/sem_grad.sv
// 3x3 window columns, Sobel gradients and saturated L1 magnitude.
module sem_grad (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_act,
    input  logic                  i_prod,
    input  sem_pkg::t_tag         i_tag,
    input  logic [sem_pkg::PixW-1:0] i_top,
    input  logic [sem_pkg::PixW-1:0] i_mid,
    input  logic [sem_pkg::PixW-1:0] i_bot,
    output logic                  o_valid,
    output sem_pkg::t_res         o_res
);
    import sem_pkg::*;

    // window: left column (lt, lm, lb) and center column (ct, cm, cb)
    logic [PixW-1:0] r_lt, r_lm, r_lb, r_ct, r_cm, r_cb;
    logic [PixW+1:0] col_l, col_r, row_t, row_b;
    logic [PixW+1:0] n_ax, n_ay;
    logic [PixW+1:0] r_ax, r_ay;
    logic            r_v2;
    t_tag            r_tag2;
    logic [PixW+2:0] sum;

    always_comb begin
        col_l = {2'b00, r_lt} + {1'b0, r_lm, 1'b0} + {2'b00, r_lb};
        col_r = {2'b00, i_top} + {1'b0, i_mid, 1'b0} + {2'b00, i_bot};
        row_t = {2'b00, r_lt} + {1'b0, r_ct, 1'b0} + {2'b00, i_top};
        row_b = {2'b00, r_lb} + {1'b0, r_cb, 1'b0} + {2'b00, i_bot};
        n_ax  = (col_r >= col_l) ? (col_r - col_l) : (col_l - col_r);
        n_ay  = (row_b >= row_t) ? (row_b - row_t) : (row_t - row_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= '0;
            r_lm <= '0;
            r_lb <= '0;
            r_ct <= '0;
            r_cm <= '0;
            r_cb <= '0;
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= i_act && i_prod;
            if (i_act) begin
                r_lt <= r_ct;
                r_lm <= r_cm;
                r_lb <= r_cb;
                r_ct <= i_top;
                r_cm <= i_mid;
                r_cb <= i_bot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax   <= n_ax;
        r_ay   <= n_ay;
        r_tag2 <= i_tag;
    end

    assign sum = {1'b0, r_ax} + {1'b0, r_ay};

    assign o_valid         = r_v2;
    assign o_res.edge_res  = (|sum[PixW+2:PixW]) ? {PixW{1'b1}} : sum[PixW-1:0];
    assign o_res.tag       = r_tag2;

endmodule

### design/sem_out_fifo.sv
// Small output queue that decouples the pipeline from output backpressure.
module sem_out_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  sem_pkg::t_res                i_wr_data,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output sem_pkg::t_res                o_rd_data,
    output logic [sem_pkg::FifoCntW-1:0] o_count
);
    import sem_pkg::*;

    t_res                r_mem [FifoDepth];
    logic [FifoPtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FifoCntW-1:0] r_count;
    logic                pop;

    assign pop = (r_count != '0) && i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr_en, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_tvalid  = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_count   = r_count;

endmodule

### design/sem_checker.sv
// Port-level checks for the Sobel edge magnitude block, bound to the top level.
module sem_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_axis_tvalid,
    input logic                         o_s_axis_tready,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [sem_pkg::PixW-1:0]     o_m_axis_tdata,
    input logic                         o_m_axis_tlast,
    input logic [0:0]                   o_m_axis_tuser
);
    import sem_pkg::*;

    logic s_xfer;
    assign s_xfer = i_s_axis_tvalid && o_s_axis_tready;

    // frame end is always also a row end
    a_frame_end_is_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> o_m_axis_tlast)
        else $error("frame end without row end");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) &&
             $stable(o_m_axis_tuser)))
        else $error("output changed while stalled");

    // an empty queue fills only from an earlier pixel transfer that has passed the stage 1 and gradient registers
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(s_xfer, 3))
        else $error("result without matching input transfer");

    // input is held off only while results are waiting
    a_ready_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with empty output");

endmodule

bind sobel_edge_magnitude_3x3 sem_checker u_sem_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
